/* rtl/lru_page_replacement_unit_defines.svh */
// Assertion macros for the LRU page replacement unit.
// Included by the top level; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrupr_pkg.sv */
// Shared types and fixed field widths for the LRU page replacement unit.
// No dependencies.
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int PAGE_NUM_W  = 16;
    localparam int FRAME_IDX_W = 2;
    localparam int COUNT_W     = 32;

    typedef struct packed {
        logic [PAGE_NUM_W-1:0] page_number;
    } t_page_req;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_NUM_W-1:0]  evicted_page;
        logic [COUNT_W-1:0]     hit_total;
        logic [COUNT_W-1:0]     fault_total;
    } t_page_rsp;

endpackage

/* rtl/lrupr_stream_if.sv */
// Valid/ready channel carrying one payload of a given type.
// No dependencies; the payload type is set where the channel is built.
`timescale 1ns / 1ps

interface lrupr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/lru_page_replacement_unit.sv */
// LRU page replacement unit: top level, fully associative frame set.
// Depends on lrupr_pkg, lrupr_stream_if and lru_page_replacement_unit_defines.svh.
`timescale 1ns / 1ps
`include "lru_page_replacement_unit_defines.svh"

//  channel   dir  payload      carries
//  i_req     in   t_page_req   page reference request (page_number)
//  o_rsp     out  t_page_rsp   hit/fault, frame, evicted page, running totals
//
//  One request per cycle sustained while o_rsp is ready. The request is
//  registered, then tag compare, victim pick and rank update run against
//  the frame state and load the result register.
//  Reset (i_rst_n low, synchronous) empties all frames and clears counters.
//  A stalled result holds in the output register; the input stage keeps
//  taking requests as long as its register drains.

module lru_page_replacement_unit #(
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lrupr_stream_if.sink   i_req,
    lrupr_stream_if.source o_rsp
);
    import lrupr_pkg::*;

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(FRAME_COUNT - 1);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [IDX_W-1:0]     t_idx;

    // Input stage
    logic  r_in_valid;
    t_page r_in_page;

    // Frame state
    t_page                  r_frame_page [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_frame_valid;
    t_rank                  r_rank [FRAME_COUNT];
    logic [COUNT_W-1:0]     r_hit_count;
    logic [COUNT_W-1:0]     r_fault_count;

    // Output stage
    logic      r_out_valid;
    t_page_rsp r_out;

    // Next values
    t_page                  n_frame_page [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] n_frame_valid;
    t_rank                  n_rank [FRAME_COUNT];
    logic [COUNT_W-1:0]     n_hit_count;
    logic [COUNT_W-1:0]     n_fault_count;
    t_page_rsp              n_out;

    logic w_advance;
    logic w_in_ready;

    logic  w_hit;
    t_idx  w_hit_idx;
    logic  w_empty_found;
    t_idx  w_empty_idx;
    t_idx  w_victim_idx;
    t_idx  w_target;
    t_rank w_target_rank;
    logic  w_fill;
    logic  w_evict;
    t_page w_in_page;

    logic [PAGE_BITS+PAGE_NUM_W-1:0]  w_in_wide;
    logic [PAGE_BITS+PAGE_NUM_W-1:0]  w_ev_wide;
    logic [IDX_W+FRAME_IDX_W-1:0]     w_idx_wide;

    // Handshake: the processing step fires when the input register holds a
    // request and the result register is free or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_in_ready  = !r_in_valid || w_advance;
    assign i_req.ready = w_in_ready;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Page number masked (or zero-extended) to PAGE_BITS.
    assign w_in_wide = {{PAGE_BITS{1'b0}}, i_req.payload.page_number};
    assign w_in_page = w_in_wide[PAGE_BITS-1:0];

    // Tag compare, first empty frame and LRU victim, all in parallel.
    always_comb begin
        w_hit         = 1'b0;
        w_hit_idx     = '0;
        w_empty_found = 1'b0;
        w_empty_idx   = '0;
        w_victim_idx  = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!w_hit && r_frame_valid[i] && (r_frame_page[i] == r_in_page)) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
            if (!w_empty_found && !r_frame_valid[i]) begin
                w_empty_found = 1'b1;
                w_empty_idx   = IDX_W'(i);
            end
            // The oldest rank is unique once every frame is valid.
            if (r_rank[i] == LRU_RANK) begin
                w_victim_idx = IDX_W'(i);
            end
        end
    end

    assign w_fill        = !w_hit && w_empty_found;
    assign w_evict       = !w_hit && !w_empty_found;
    assign w_target      = w_hit ? w_hit_idx : (w_empty_found ? w_empty_idx : w_victim_idx);
    assign w_target_rank = r_rank[w_target];

    // Frame and rank update. An empty frame counts as older than every valid
    // one, so all valid frames age by one on a fill.
    always_comb begin
        n_frame_valid = r_frame_valid;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            n_frame_page[i] = r_frame_page[i];
            n_rank[i]       = r_rank[i];
            if (w_target == IDX_W'(i)) begin
                n_rank[i] = '0;
                if (!w_hit) begin
                    n_frame_page[i] = r_in_page;
                end
                if (w_fill) begin
                    n_frame_valid[i] = 1'b1;
                end
            end else if (r_frame_valid[i] && (w_fill || (r_rank[i] < w_target_rank))) begin
                n_rank[i] = RANK_W'(r_rank[i] + 1'b1);
            end
        end
    end

    // Saturating totals.
    always_comb begin
        n_hit_count   = r_hit_count;
        n_fault_count = r_fault_count;
        if (w_hit) begin
            if (r_hit_count != '1) begin
                n_hit_count = r_hit_count + 1'b1;
            end
        end else begin
            if (r_fault_count != '1) begin
                n_fault_count = r_fault_count + 1'b1;
            end
        end
    end

    assign w_ev_wide  = {{PAGE_NUM_W{1'b0}}, r_frame_page[w_victim_idx]};
    assign w_idx_wide = {{FRAME_IDX_W{1'b0}}, w_target};

    always_comb begin
        n_out.hit           = w_hit;
        n_out.frame_index   = w_idx_wide[FRAME_IDX_W-1:0];
        n_out.evicted_valid = w_evict;
        n_out.evicted_page  = w_evict ? w_ev_wide[PAGE_NUM_W-1:0] : '0;
        n_out.hit_total     = n_hit_count;
        n_out.fault_total   = n_fault_count;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_frame_valid <= '0;
            r_hit_count   <= '0;
            r_fault_count <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_frame_valid <= n_frame_valid;
                r_hit_count   <= n_hit_count;
                r_fault_count <= n_fault_count;
                for (int i = 0; i < FRAME_COUNT; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, qualified by the valid bits above.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_in_ready) begin
            r_in_page <= w_in_page;
        end
        if (w_advance) begin
            r_out <= n_out;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_frame_page[i] <= n_frame_page[i];
            end
        end
    end

    // Frames fill from the lowest index and are never emptied.
    `LRUPR_ASSERT_NOW(a_valid_prefix, i_clk, i_rst_n, 1'b1, ((r_frame_valid & (r_frame_valid + 1'b1)) == '0), "frame valid bits not a low prefix")
    // An eviction is reported only when every frame is occupied.
    `LRUPR_ASSERT_NOW(a_evict_full, i_clk, i_rst_n, (w_advance && w_evict), (&r_frame_valid), "eviction with an empty frame")
    // Each processed request bumps exactly one total unless it saturated.
    `LRUPR_ASSERT_NEXT(a_totals_step, i_clk, i_rst_n, (w_advance && (r_hit_count != '1) && (r_fault_count != '1)), ((r_hit_count + r_fault_count) == ($past(r_hit_count) + $past(r_fault_count) + 1'b1)), "totals did not advance by one")

endmodule

/* tb/tb.sv */
// Self-checking testbench for lru_page_replacement_unit: every page reference
// is predicted by an in-bench frame/recency model and compared in order.
// Depends on lrupr_pkg, lrupr_stream_if and the RTL top level.
`timescale 1ns / 1ps

module tb;
    import lrupr_pkg::*;

    localparam int FRAMES = 4;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam int RX_HOLD_CYCLES = 300;

    // Opening sequence: page zero into an empty set, bit extremes, hits on the
    // MRU, middle and LRU frames, and evictions once all frames are full.
    localparam logic [PAGE_NUM_W-1:0] DIRECTED_PAGES [20] = '{
        16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
        16'h0001, 16'h0000, 16'h1234, 16'hFFFF, 16'h7FFF,
        16'h1234, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h0000,
        16'h7FFF, 16'h5555, 16'hFFFE, 16'h0001, 16'hAAAA
    };

    typedef struct {
        t_page_req req;
        t_page_rsp rsp;
    } t_ref_outcome;

    // Frame set shadow plus the queue of outcomes still owed by the block.
    class lru_frame_scoreboard;
        logic [PAGE_NUM_W-1:0] frame_page [FRAMES];
        bit                    frame_valid[FRAMES];
        int unsigned           frame_rank [FRAMES];
        logic [COUNT_W-1:0]    hits;
        logic [COUNT_W-1:0]    faults;
        t_ref_outcome          outcome_q[$];
        int unsigned           errors;
        int unsigned           checked;
        int unsigned           hit_seen;
        int unsigned           evict_seen;

        function new();
            foreach (frame_page[i]) begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                frame_rank[i]  = 0;
            end
            hits       = '0;
            faults     = '0;
            errors     = 0;
            checked    = 0;
            hit_seen   = 0;
            evict_seen = 0;
        endfunction

        // Accepted reference: update the frame set and queue the outcome.
        function void note_reference(t_page_req r);
            t_ref_outcome e;
            int unsigned  tgt;
            int unsigned  used;
            int unsigned  old_rank;
            bit           found;
            found = 1'b0;
            tgt   = 0;
            used  = 0;
            e.req = r;
            e.rsp = '0;
            // empty frames never match, even when they hold page zero
            for (int i = 0; i < FRAMES; i++) begin
                if (frame_valid[i]) begin
                    used++;
                    if (!found && frame_page[i] == r.page_number) begin
                        found = 1'b1;
                        tgt   = i;
                    end
                end
            end
            if (found) begin
                old_rank = frame_rank[tgt];
                hits = (hits == COUNT_SAT) ? hits : hits + 1'b1;
            end else begin
                if (used < FRAMES) begin
                    // lowest empty frame; it counts as older than every valid one
                    for (int i = FRAMES - 1; i >= 0; i--)
                        if (!frame_valid[i]) tgt = i;
                    old_rank = used;
                    frame_valid[tgt] = 1'b1;
                end else begin
                    // victim holds the oldest rank, which is unique
                    for (int i = 0; i < FRAMES; i++)
                        if (frame_rank[i] >= frame_rank[tgt]) tgt = i;
                    e.rsp.evicted_valid = 1'b1;
                    e.rsp.evicted_page  = frame_page[tgt];
                    old_rank = frame_rank[tgt];
                end
                frame_page[tgt] = r.page_number;
                faults = (faults == COUNT_SAT) ? faults : faults + 1'b1;
            end
            for (int i = 0; i < FRAMES; i++)
                if (i != tgt && frame_valid[i] && frame_rank[i] < old_rank)
                    frame_rank[i]++;
            frame_rank[tgt] = 0;
            e.rsp.hit         = found;
            e.rsp.frame_index = tgt[FRAME_IDX_W-1:0];
            e.rsp.hit_total   = hits;
            e.rsp.fault_total = faults;
            outcome_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_outcome(t_page_rsp got);
            t_ref_outcome e;
            if (outcome_q.size() == 0) begin
                report_mismatch("response with no reference outstanding");
                return;
            end
            e = outcome_q.pop_front();
            checked++;
            if (e.rsp.hit) hit_seen++;
            if (e.rsp.evicted_valid) evict_seen++;
            if (got.hit !== e.rsp.hit)
                report_mismatch($sformatf("page %h: hit %b, want %b",
                    e.req.page_number, got.hit, e.rsp.hit));
            if (got.frame_index !== e.rsp.frame_index)
                report_mismatch($sformatf("page %h: frame %0d, want %0d",
                    e.req.page_number, got.frame_index, e.rsp.frame_index));
            if (got.evicted_valid !== e.rsp.evicted_valid)
                report_mismatch($sformatf("page %h: evicted_valid %b, want %b",
                    e.req.page_number, got.evicted_valid, e.rsp.evicted_valid));
            if (got.evicted_page !== e.rsp.evicted_page)
                report_mismatch($sformatf("page %h: evicted_page %h, want %h",
                    e.req.page_number, got.evicted_page, e.rsp.evicted_page));
            if (got.hit_total !== e.rsp.hit_total)
                report_mismatch($sformatf("page %h: hit_total %0d, want %0d",
                    e.req.page_number, got.hit_total, e.rsp.hit_total));
            if (got.fault_total !== e.rsp.fault_total)
                report_mismatch($sformatf("page %h: fault_total %0d, want %0d",
                    e.req.page_number, got.fault_total, e.rsp.fault_total));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;

    lru_frame_scoreboard sb = new();

    lrupr_stream_if #(.t_payload(t_page_req)) req_ch ();
    lrupr_stream_if #(.t_payload(t_page_rsp)) rsp_ch ();

    lru_page_replacement_unit #(
        .FRAME_COUNT(FRAMES),
        .PAGE_BITS  (PAGE_NUM_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Offer one page reference, with random idle cycles ahead of it, and wait
    // until the block takes it. Handshake signals are sampled right after the
    // edge, so they hold their pre-edge values.
    task automatic send_page(input logic [PAGE_NUM_W-1:0] pg);
        t_page_req r;
        r.page_number = pg;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_reference(r);
    endtask

    // Mostly draws from a small working set that is renewed every few dozen
    // references, so hits, fills and evictions all keep occurring; the rest
    // are arbitrary pages that almost always fault.
    task automatic run_random(input int count);
        logic [PAGE_NUM_W-1:0] pool [6];
        int unsigned           span;
        span = 5;
        for (int n = 0; n < count; n++) begin
            if (n % 48 == 0) begin
                foreach (pool[k]) pool[k] = PAGE_NUM_W'($urandom);
                span = $urandom_range(3, 5);
            end
            if ($urandom_range(0, 99) < 85)
                send_page(pool[$urandom_range(0, span)]);
            else
                send_page(PAGE_NUM_W'($urandom));
        end
    endtask

    // Response side: check every accepted response, then pick the next ready.
    // Once 60 responses are in, ready is held low for a long stretch while the
    // request side keeps offering, which backs the block up to its input.
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_outcome(rsp_ch.payload);
            if (!hold_done && sb.checked == 60) begin
                hold_left = RX_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        tx_idle_pct    = 22;
        rx_idle_pct    = 68;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_PAGES[k]) send_page(DIRECTED_PAGES[k]);
        run_random(450);

        // swap the idle mix: slow sender, eager receiver
        tx_idle_pct = 68;
        rx_idle_pct = 22;
        run_random(440);

        // back to back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(440);
        req_ch.valid <= 1'b0;

        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        // any stray response shows up well within this wait
        repeat (10) @(posedge i_clk);

        $display("Checked %0d page references: %0d hits, %0d faults, %0d evictions.",
                 sb.checked, sb.hit_seen, sb.checked - sb.hit_seen, sb.evict_seen);
        $display("Covered three idle mixes and a %0d-cycle response stall.",
                 RX_HOLD_CYCLES);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Safety stop, far beyond the slowest correct run.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_stream_if.sv
rtl/lru_page_replacement_unit.sv
tb/tb.sv
